[hdl/ptgs_pkg.sv]
// Shared types, constants and the log2 fraction table generator for the
// peak-tracking gain slew block. No dependencies.
`default_nettype none

package ptgs_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 15;
  localparam int GAIN_W     = 21;
  localparam int RATE_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int RATE_SHIFT = 8;
  localparam int LOG_D_W    = 20;
  localparam int DBO_W      = 19;
  localparam int PROD_W     = LOG_D_W + DBO_W;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE = CFG_IDX_W'(1);

  localparam logic [PEAK_W-1:0]   PEAK_LIMIT        = 15'h7FFF;
  // 15.0 in Q16: log2 of full scale (32768).
  localparam logic [LOG_D_W-1:0]  LOG_FULL_SCALE    = 20'hF0000;
  // round(20*log10(2) * 2^16): dB per octave in Q16.
  localparam logic [DBO_W-1:0]    DB_PER_OCTAVE_Q16 = 19'd394566;
  localparam logic [PROD_W-1:0]   PROD_ROUND        = PROD_W'(32768);
  localparam logic signed [23:0]  HEADROOM_Q16      = 24'sd131072;
  localparam logic signed [23:0]  GAIN_CEILING_Q16  = 24'sd786432;

  // Result of the peak tracker, one per accepted sample.
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              rose;
    logic [PEAK_W-1:0] peak;
  } blk_t;

  // Target candidate leaving the log/multiply pipeline.
  typedef struct packed {
    logic                     valid;
    logic                     last;
    logic                     rose;
    logic [PEAK_W-1:0]        peak;
    logic signed [GAIN_W-1:0] cand;
  } tgt_t;

  // log2(1 + idx/2^fbits) in Q16, found bit by bit through repeated squaring
  // in Q30. Only ever called with constant arguments to build a table.
  function automatic logic [15:0] frac_log2_q16(input int unsigned idx,
                                                input int unsigned fbits);
    logic [63:0] x;
    logic [17:0] r;
    logic [18:0] rr;
    x = (64'd1 << 30) + (64'(idx) << (30 - fbits));
    r = '0;
    for (int k = 0; k < 18; k++) begin
      x = (x * x) >> 30;
      r = {r[16:0], 1'b0};
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r[0] = 1'b1;
      end
    end
    rr = 19'(r) + 19'd2;
    return rr[17:2];
  endfunction

endpackage

`default_nettype wire

[hdl/ptgs_in_if.sv]
// Sample request channel: valid/ready plus one audio sample and block marker.
// Depends on ptgs_pkg.
`default_nettype none

interface ptgs_in_if import ptgs_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_block;

  modport source (output valid, sample, last_in_block, input ready);
  modport sink   (input valid, sample, last_in_block, output ready);
endinterface

`default_nettype wire

[hdl/ptgs_out_if.sv]
// Result request channel: valid/ready plus gain and held peak.
// Depends on ptgs_pkg.
`default_nettype none

interface ptgs_out_if import ptgs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [GAIN_W-1:0] gain_db;
  logic [PEAK_W-1:0]        held_peak;

  modport source (output valid, gain_db, held_peak, input ready);
  modport sink   (input valid, gain_db, held_peak, output ready);
endinterface

`default_nettype wire

[hdl/ptgs_cfg_if.sv]
// Configuration write channel: valid/ready plus register index and data.
// Depends on ptgs_pkg.
`default_nettype none

interface ptgs_cfg_if import ptgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/ptgs_track.sv]
// Input register, sample magnitude, block peak, block length and running peak.
// Depends on ptgs_pkg.
`default_nettype none

module ptgs_track import ptgs_pkg::*; #(
  parameter int MAX_BLOCK = 4096,
  parameter int N_W       = 13
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_valid,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_last,
  output blk_t                            blk,
  output logic [N_W-1:0]                  blk_n
);

  logic                       a_valid;
  logic signed [SAMPLE_W-1:0] a_sample;
  logic                       a_last;

  logic [PEAK_W-1:0] running_peak;
  logic [PEAK_W-1:0] block_peak;
  logic [N_W-1:0]    block_length;

  logic [SAMPLE_W-1:0] neg;
  logic [PEAK_W-1:0]   mag;
  logic [PEAK_W-1:0]   bp_new;
  logic [PEAK_W-1:0]   peak;
  logic [N_W-1:0]      n;

  always_comb begin
    neg = SAMPLE_W'(0) - SAMPLE_W'(a_sample);
    if (a_sample[SAMPLE_W-1]) begin
      // The most negative sample has no positive twin and saturates.
      mag = neg[SAMPLE_W-1] ? PEAK_LIMIT : neg[PEAK_W-1:0];
    end else begin
      mag = a_sample[PEAK_W-1:0];
    end
    bp_new = (mag > block_peak) ? mag : block_peak;
    peak   = (bp_new > running_peak) ? bp_new : running_peak;
    n      = (block_length >= N_W'(MAX_BLOCK)) ? N_W'(MAX_BLOCK) : block_length + N_W'(1);
  end

  // Control and state are reset; the data fields simply follow the stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_sample <= in_sample;
      a_last   <= in_last;
      blk.last <= a_last;
      blk.rose <= (peak != running_peak);
      blk.peak <= peak;
      blk_n    <= n;
    end
    if (rst) begin
      a_valid      <= 1'b0;
      running_peak <= '0;
      block_peak   <= '0;
      block_length <= '0;
      blk.valid    <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      blk.valid <= a_valid;
      if (a_valid) begin
        if (a_last) begin
          running_peak <= peak;
          block_peak   <= '0;
          block_length <= '0;
        end else begin
          block_peak   <= bp_new;
          block_length <= n;
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ptgs_target.sv]
// Target gain pipeline: leading one and log2 table, dB scaling multiply,
// rounding and clamp; also the per-block slew limits. Depends on ptgs_pkg.
`default_nettype none

module ptgs_target import ptgs_pkg::*; #(
  parameter int LOG_FRACTION_BITS = 8,
  parameter int N_W               = 13,
  parameter int UP_W              = 21
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire blk_t              blk,
  input  wire logic [N_W-1:0]    blk_n,
  input  wire logic [RATE_W-1:0] rise_rate,
  input  wire logic [RATE_W-1:0] fall_rate,
  output tgt_t                   tgt,
  output logic [UP_W-1:0]        up,
  output logic [UP_W-1:0]        down
);

  localparam int TAB_SIZE = 1 << LOG_FRACTION_BITS;
  localparam int MUL_W    = RATE_W + N_W;

  logic [15:0] log_rom [TAB_SIZE];

  for (genvar i = 0; i < TAB_SIZE; i++) begin : g_rom
    assign log_rom[i] = frac_log2_q16(i, LOG_FRACTION_BITS);
  end

  // Stage C: log2 of the peak, and the slew limits.
  logic [3:0]                   lead;
  logic [PEAK_W-1:0]            norm;
  logic [LOG_FRACTION_BITS-1:0] idx;
  logic [LOG_D_W-1:0]           log_d;
  logic [MUL_W-1:0]             up_full;
  logic [MUL_W-1:0]             dn_full;

  always_comb begin
    lead = '0;
    for (int b = 1; b < PEAK_W; b++) begin
      if (blk.peak[b]) lead = 4'(b);
    end
    norm    = blk.peak << (4'd14 - lead);
    idx     = norm[PEAK_W-2 -: LOG_FRACTION_BITS];
    log_d   = LOG_FULL_SCALE - {lead, log_rom[idx]};
    up_full = MUL_W'(rise_rate) * MUL_W'(blk_n);
    dn_full = MUL_W'(fall_rate) * MUL_W'(blk_n);
  end

  logic               c_valid, c_last, c_rose, c_zero;
  logic [PEAK_W-1:0]  c_peak;
  logic [LOG_D_W-1:0] c_d;
  logic [UP_W-1:0]    c_up, c_dn;

  // Stage D: scale octaves to dB.
  logic               d_valid, d_last, d_rose, d_zero;
  logic [PEAK_W-1:0]  d_peak;
  logic [PROD_W-1:0]  d_prod;
  logic [UP_W-1:0]    d_up, d_dn;

  // Stage E: round, remove headroom, clamp.
  logic [PROD_W-1:0]   rounded;
  logic signed [23:0]  g;
  logic signed [GAIN_W-1:0] cand;

  always_comb begin
    rounded = d_prod + PROD_ROUND;
    g       = $signed({1'b0, rounded[PROD_W-1:16]}) - HEADROOM_Q16;
    if (d_zero || g > GAIN_CEILING_Q16) begin
      cand = GAIN_W'(GAIN_CEILING_Q16);
    end else begin
      cand = g[GAIN_W-1:0];
    end
  end

  // Valid bits are reset; the data fields simply follow their stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      c_last   <= blk.last;
      c_rose   <= blk.rose;
      c_zero   <= (blk.peak == '0);
      c_peak   <= blk.peak;
      c_d      <= log_d;
      c_up     <= up_full[MUL_W-1:RATE_SHIFT];
      c_dn     <= dn_full[MUL_W-1:RATE_SHIFT];

      d_last   <= c_last;
      d_rose   <= c_rose;
      d_zero   <= c_zero;
      d_peak   <= c_peak;
      d_prod   <= PROD_W'(c_d) * PROD_W'(DB_PER_OCTAVE_Q16);
      d_up     <= c_up;
      d_dn     <= c_dn;

      tgt.last <= d_last;
      tgt.rose <= d_rose;
      tgt.peak <= d_peak;
      tgt.cand <= cand;
      up       <= d_up;
      down     <= d_dn;
    end
    if (rst) begin
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      tgt.valid <= 1'b0;
    end else if (adv) begin
      c_valid   <= blk.valid;
      d_valid   <= c_valid;
      tgt.valid <= d_valid;
    end
  end

endmodule

`default_nettype wire

[hdl/ptgs_slew.sv]
// Target and present gain registers, slew step and the result register.
// Depends on ptgs_pkg.
`default_nettype none

module ptgs_slew import ptgs_pkg::*; #(
  parameter int UP_W = 21
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                adv,
  input  wire tgt_t                tgt,
  input  wire logic [UP_W-1:0]     up,
  input  wire logic [UP_W-1:0]     down,
  output logic                     res_valid,
  output logic signed [GAIN_W-1:0] res_gain,
  output logic [PEAK_W-1:0]        res_peak
);

  localparam int CW = ((UP_W + 1 > GAIN_W) ? UP_W + 1 : GAIN_W) + 1;

  logic signed [GAIN_W-1:0] target_gain;
  logic signed [GAIN_W-1:0] present_gain;
  logic signed [GAIN_W-1:0] tgt_now;
  logic signed [GAIN_W-1:0] present_next;
  logic signed [CW-1:0]     cur_x, tgt_x, up_x, dn_x, sum_x;

  always_comb begin
    tgt_now = tgt.rose ? tgt.cand : target_gain;
    cur_x   = CW'(present_gain);
    tgt_x   = CW'(tgt_now);
    up_x    = $signed(CW'(up));
    dn_x    = $signed(CW'(down));
    if (cur_x < tgt_x - up_x) begin
      sum_x = cur_x + up_x;
    end else if (cur_x > tgt_x + dn_x) begin
      sum_x = cur_x - dn_x;
    end else begin
      sum_x = tgt_x;
    end
    present_next = sum_x[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_gain  <= '0;
      present_gain <= '0;
      res_valid    <= 1'b0;
    end else if (adv) begin
      res_valid <= tgt.valid && tgt.last;
      if (tgt.valid && tgt.last) begin
        target_gain  <= tgt_now;
        present_gain <= present_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tgt.valid && tgt.last) begin
      res_gain <= present_next;
      res_peak <= tgt.peak;
    end
  end

endmodule

`default_nettype wire

[hdl/peak_tracking_gain_slew.sv]
// Peak-tracking gain slew: one sample request accepted per cycle, except
// while a result is held unread in the result register. A block's result
// request passes the input register, peak tracker, log lookup, dB multiply,
// round/clamp and slew into the result register before result.valid rises.
// Reset (rst, synchronous) clears peaks, block length, gains and both rates.
// Depends on ptgs_pkg, the three channel interfaces and the ptgs_* stages.
`default_nettype none

module peak_tracking_gain_slew import ptgs_pkg::*; #(
  parameter int MAX_BLOCK         = 4096,
  parameter int LOG_FRACTION_BITS = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  ptgs_cfg_if.sink  cfg,
  ptgs_in_if.sink   stream,
  ptgs_out_if.source result
);

  // Block length counter width: it must hold MAX_BLOCK itself.
  localparam int N_W  = $clog2(MAX_BLOCK + 1);
  // Slew limit per block: rate times length, dropping eight fraction bits.
  localparam int UP_W = RATE_W + N_W - RATE_SHIFT;

  // The whole pipeline moves as one. It only stops when a finished result is
  // still held in the result register and the sink is not taking it, so a
  // result leaving and a new sample arriving can share the same edge.
  logic adv;
  assign adv          = !result.valid || result.ready;
  assign stream.ready = adv;

  // Configuration writes are always taken; unknown indexes fall through.
  logic [RATE_W-1:0] rise_rate;
  logic [RATE_W-1:0] fall_rate;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rise_rate <= '0;
      fall_rate <= '0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_RISE_RATE: rise_rate <= cfg.data;
        REG_FALL_RATE: fall_rate <= cfg.data;
        default: ;
      endcase
    end
  end

  blk_t           blk;
  logic [N_W-1:0] blk_n;
  tgt_t           tgt;
  logic [UP_W-1:0] up;
  logic [UP_W-1:0] down;

  // Sample magnitude, per-block peak and length, running peak.
  ptgs_track #(
    .MAX_BLOCK (MAX_BLOCK),
    .N_W       (N_W)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (stream.valid),
    .in_sample (stream.sample),
    .in_last   (stream.last_in_block),
    .blk       (blk),
    .blk_n     (blk_n)
  );

  // Log2 of the peak, conversion to dB with headroom and ceiling, and the
  // rise/fall limits for this block.
  ptgs_target #(
    .LOG_FRACTION_BITS (LOG_FRACTION_BITS),
    .N_W               (N_W),
    .UP_W              (UP_W)
  ) u_target (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .blk       (blk),
    .blk_n     (blk_n),
    .rise_rate (rise_rate),
    .fall_rate (fall_rate),
    .tgt       (tgt),
    .up        (up),
    .down      (down)
  );

  // Present gain steps toward the target; only final samples of a block
  // produce a result request.
  ptgs_slew #(
    .UP_W (UP_W)
  ) u_slew (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .tgt       (tgt),
    .up        (up),
    .down      (down),
    .res_valid (result.valid),
    .res_gain  (result.gain_db),
    .res_peak  (result.held_peak)
  );

endmodule

`default_nettype wire

[test/tb_peak_tracking_gain_slew.sv]
// Self-checking testbench for peak_tracking_gain_slew: drives sample requests in
// blocks, predicts each per-block gain report and compares it with the result channel.
// Depends on ptgs_pkg, the three ptgs channel interfaces and the block itself.
`timescale 1ns / 100ps

module tb_peak_tracking_gain_slew;
  import ptgs_pkg::*;

  localparam int MAX_BLOCK       = 4096;
  localparam int FRAC_BITS       = 8;
  localparam int FRAC_ENTRIES    = 1 << FRAC_BITS;
  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 5;
  // Trailing non-final samples must drain through the pipeline stages.
  localparam int SETTLE_CYCLES   = 12;
  localparam int RAND_PHASES     = 5;
  localparam int ITEMS_PER_PHASE = 375;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 25;
  localparam int WATCHDOG_LIMIT  = 5000;
  localparam int MAX_REPORTED    = 10;

  // Register indexes that the block does not implement; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_req_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_db;
    logic [PEAK_W-1:0]        held_peak;
  } gain_report_t;

  logic clk;
  logic rst;

  ptgs_cfg_if cfg_ch();
  ptgs_in_if  sample_ch();
  ptgs_out_if result_ch();

  peak_tracking_gain_slew #(
    .MAX_BLOCK(MAX_BLOCK),
    .LOG_FRACTION_BITS(FRAC_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .stream(sample_ch),
    .result(result_ch)
  );

  // ---------------------------------------------------------------------------
  // Gain predictor. It mirrors the block's architectural state: rates, the
  // never-decaying held peak, the peak and length of the open block, and the
  // target and present gains (both in 2^-16 dB).
  // ---------------------------------------------------------------------------
  int unsigned  log2_frac_q16 [FRAC_ENTRIES];
  int unsigned  rise_per_sample;
  int unsigned  fall_per_sample;
  int unsigned  peak_held;
  int unsigned  peak_in_block;
  int unsigned  samples_in_block;
  longint       gain_goal;
  longint       gain_now;
  gain_report_t gain_reports_due[$];

  // log2(1 + i/2^FRAC_BITS) in Q16. The integer part of x*x tells whether the
  // next fraction bit is set; 18 bits are kept and rounded half up to 16.
  function automatic int unsigned log2_frac_entry(input int unsigned i);
    longint unsigned x;
    int unsigned     r;
    x = (64'd1 << 30) + (longint'(i) << (30 - FRAC_BITS));
    r = 0;
    for (int k = 0; k < 18; k++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        r = r | 1;
      end
    end
    return (r + 2) >> 2;
  endfunction

  // Target gain for a nonzero peak: 20*log10(32768/peak) - 2 dB, capped at 12 dB.
  // The leading-one position gives the integer part of log2, the next FRAC_BITS
  // bits index the fraction table.
  function automatic longint target_for_peak(input int unsigned p);
    int unsigned e;
    int unsigned idx;
    longint      lg;
    longint      diff;
    longint      g;
    if (p == 0) return longint'(GAIN_CEILING_Q16);
    e = 0;
    while (e < 14 && (p >> (e + 1)) != 0) e++;
    idx  = ((p << FRAC_BITS) >> e) & (FRAC_ENTRIES - 1);
    lg   = longint'(e) * 65536 + longint'(log2_frac_q16[idx]);
    diff = longint'(LOG_FULL_SCALE) - lg;
    g    = ((diff * longint'(DB_PER_OCTAVE_Q16) + 32768) >>> 16) - longint'(HEADROOM_Q16);
    if (g > longint'(GAIN_CEILING_Q16)) g = longint'(GAIN_CEILING_Q16);
    return g;
  endfunction

  // Applies one accepted sample request to the predictor. A final sample closes
  // the block and queues the gain report the block must emit for it.
  function automatic void advance_agc(input sample_req_t req);
    int          mag;
    int unsigned n;
    longint      up;
    longint      down;
    mag = int'(req.sample);
    if (mag < 0) mag = -mag;
    if (mag > 32767) mag = 32767;
    if (mag > peak_in_block) peak_in_block = mag;
    n = samples_in_block + 1;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    if (!req.last) begin
      samples_in_block = n;
      return;
    end
    // The target only moves when the held peak rises; otherwise it is kept.
    if (peak_in_block > peak_held) begin
      peak_held = peak_in_block;
      gain_goal = target_for_peak(peak_held);
    end
    if (gain_now != gain_goal) begin
      up   = (longint'(rise_per_sample) * n) >> RATE_SHIFT;
      down = (longint'(fall_per_sample) * n) >> RATE_SHIFT;
      if (gain_now < gain_goal - up) gain_now = gain_now + up;
      else if (gain_now > gain_goal + down) gain_now = gain_now - down;
      else gain_now = gain_goal;
    end
    peak_in_block    = 0;
    samples_in_block = 0;
    gain_reports_due.push_back('{gain_db: GAIN_W'(gain_now), held_peak: PEAK_W'(peak_held)});
  endfunction

  // ---------------------------------------------------------------------------
  // Clock.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sample driver. The stimulus process fills pending_samples at falling edges;
  // this block offers them one by one, holding a request until it is accepted.
  // Between requests it may insert an idle burst of random length.
  // ---------------------------------------------------------------------------
  sample_req_t pending_samples[$];
  sample_req_t in_flight;
  bit          idle_on;
  int          in_gap;
  int          samples_taken;

  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid         <= 1'b0;
      sample_ch.sample        <= '0;
      sample_ch.last_in_block <= 1'b0;
      in_gap = 0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        advance_agc(in_flight);
        samples_taken++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          sample_ch.valid <= 1'b0;
        end else if (idle_on && pending_samples.size() != 0 && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 12);
          sample_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_flight = pending_samples.pop_front();
          sample_ch.valid         <= 1'b1;
          sample_ch.sample        <= in_flight.sample;
          sample_ch.last_in_block <= in_flight.last;
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver. Every accepted gain report is checked against
  // the oldest prediction. Ready drops in random bursts, and once, after a few
  // reports, for a long hold so the pipeline stalls and back-pressures the input.
  // ---------------------------------------------------------------------------
  gain_report_t due;
  int           reports_seen;
  int           mismatch_count;
  int           out_gap;
  int           hold_left;
  bit           long_hold_done;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      out_gap   = 0;
      hold_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        reports_seen++;
        if (gain_reports_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTED)
            $display("gain report %0d arrived with none predicted: gain %0d peak %0d",
                     reports_seen, result_ch.gain_db, result_ch.held_peak);
        end else begin
          due = gain_reports_due.pop_front();
          if (result_ch.gain_db !== due.gain_db || result_ch.held_peak !== due.held_peak) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTED)
              $display("gain report %0d: expected gain %0d peak %0d, got gain %0d peak %0d",
                       reports_seen, due.gain_db, due.held_peak,
                       result_ch.gain_db, result_ch.held_peak);
          end
        end
      end
      if (!long_hold_done && idle_on && reports_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        result_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 11) == 0) begin
        out_gap = $urandom_range(0, 12);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run when no request moves on any channel for too long.
  // The longest legal quiet stretch is the long receiver hold plus one burst.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if ((cfg_ch.valid && cfg_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
          (result_ch.valid && result_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no request moved for %0d cycles, %0d gain reports outstanding",
                 quiet_cycles, gain_reports_due.size());
        $display("tb_peak_tracking_gain_slew NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  int rate_settings;

  // One register write; the predictor takes the new rate when the request is
  // accepted. Returns at a falling edge so the caller can queue samples safely.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_RISE_RATE: rise_per_sample = val;
      REG_FALL_RATE: fall_per_sample = val;
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_rates(input int unsigned rise, input int unsigned fall);
    write_reg(REG_RISE_RATE, CFG_DATA_W'(rise));
    write_reg(REG_FALL_RATE, CFG_DATA_W'(fall));
    rate_settings++;
  endtask

  function automatic void queue_sample(input int s, input bit last);
    pending_samples.push_back('{sample: SAMPLE_W'(s), last: last});
  endfunction

  // Random sample whose magnitude stays within cap, either sign.
  function automatic int draw_sample(input int cap);
    int m;
    m = $urandom_range(0, cap);
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  // Waits until every queued sample is accepted and every report has come,
  // then lets the pipeline drain samples that produce no report.
  task automatic settle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || sample_ch.valid || gain_reports_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. The held peak never decays and reset comes only once, so the
  // amplitude is raised gradually: the directed part stays at small peaks, the
  // random phases ramp the magnitude cap toward full scale, and the full-scale
  // extremes come last. Targets below the 12 dB ceiling only appear for peaks
  // above roughly 6500, which is where most random blocks end up.
  // ---------------------------------------------------------------------------
  initial begin
    int cap;
    int len;
    int queued;
    int done_items;

    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = '0;
    cfg_ch.data             = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.sample        = '0;
    sample_ch.last_in_block = 1'b0;
    result_ch.ready         = 1'b0;
    idle_on                 = 1'b0;
    for (int i = 0; i < FRAC_ENTRIES; i++) log2_frac_q16[i] = log2_frac_entry(i);
    rise_per_sample  = 0;
    fall_per_sample  = 0;
    peak_held        = 0;
    peak_in_block    = 0;
    samples_in_block = 0;
    gain_goal        = 0;
    gain_now         = 0;

    rst = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // Directed part: maximum rates, writes to unimplemented indexes, then
    // small blocks covering zero samples, the smallest nonzero peak, negative
    // samples that do not raise the peak, and peaks on either side of 256.
    set_rates(16'hFFFF, 16'hFFFF);
    write_reg(REG_SPARE, 16'h0001);
    write_reg(REG_TOP, 16'hA5A5);
    queue_sample(0, 1'b1);
    queue_sample(0, 1'b0);
    queue_sample(0, 1'b0);
    queue_sample(0, 1'b1);
    queue_sample(1, 1'b1);
    queue_sample(-1, 1'b1);
    queue_sample(2, 1'b0);
    queue_sample(-3, 1'b1);
    queue_sample(3, 1'b1);
    queue_sample(128, 1'b0);
    queue_sample(-255, 1'b1);
    queue_sample(256, 1'b1);
    queue_sample(-257, 1'b0);
    queue_sample(100, 1'b0);
    queue_sample(-100, 1'b1);
    queue_sample(257, 1'b1);
    settle();

    // Random phases, each with its own rate setting: both rates frozen, slow,
    // arbitrary, fast rise with slow fall, and slow rise with fast fall.
    done_items = 0;
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_rates(0, 0);
        1: set_rates($urandom_range(1, 300), $urandom_range(1, 300));
        2: set_rates($urandom_range(0, 65535), $urandom_range(0, 65535));
        3: set_rates(65535, $urandom_range(1, 64));
        default: set_rates($urandom_range(1, 64), 65535);
      endcase
      queued = 0;
      while (queued < ITEMS_PER_PHASE) begin
        cap = 300 + (32467 * (done_items + queued)) / (RAND_PHASES * ITEMS_PER_PHASE);
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(1, 12);
        for (int j = 0; j < len; j++) queue_sample(draw_sample(cap), j == len - 1);
        queued += len;
      end
      // Leave a block open across the next rate change: the rate in force at
      // its final sample is the one that applies.
      if (ph == 3) begin
        for (int j = 0; j < 3; j++) queue_sample(draw_sample(cap), 1'b0);
      end
      done_items += queued;
      settle();
    end

    // Last part, without idling on either side: full-scale extremes, the most
    // negative sample saturating to 32767, then full-range random blocks.
    idle_on = 1'b0;
    set_rates($urandom_range(0, 65535), $urandom_range(0, 65535));
    queue_sample(32767, 1'b1);
    queue_sample(-32768, 1'b1);
    queue_sample(-32767, 1'b0);
    queue_sample(0, 1'b1);
    queue_sample(-32768, 1'b0);
    queue_sample(32767, 1'b1);
    for (int b = 0; b < 12; b++) begin
      len = $urandom_range(1, 8);
      for (int j = 0; j < len; j++)
        queue_sample(int'($signed(16'($urandom_range(0, 65535)))), j == len - 1);
    end
    settle();

    if (gain_reports_due.size() != 0) begin
      mismatch_count++;
      $display("%0d predicted gain reports never arrived", gain_reports_due.size());
    end
    $display("covered %0d sample requests and %0d gain reports over %0d rate settings",
             samples_taken, reports_seen, rate_settings);
    $display("held peak ended at %0d, gain at %0d, mismatches %0d",
             peak_held, gain_now, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_peak_tracking_gain_slew OK");
    end else begin
      $display("tb_peak_tracking_gain_slew NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
hdl/ptgs_pkg.sv
hdl/ptgs_in_if.sv
hdl/ptgs_out_if.sv
hdl/ptgs_cfg_if.sv
hdl/ptgs_track.sv
hdl/ptgs_target.sv
hdl/ptgs_slew.sv
hdl/peak_tracking_gain_slew.sv
test/tb_peak_tracking_gain_slew.sv
